@@ rtl/id3tfx_pkg.sv @@
// ----------------------------------------------------------------------------
// id3tfx_pkg
// Shared codes and types of the ID3v2 text frame extractor.
// ----------------------------------------------------------------------------
package id3tfx_pkg;

	// Result event codes
	localparam logic [1:0] EV_TEXT  = 2'd0;
	localparam logic [1:0] EV_END   = 2'd1;
	localparam logic [1:0] EV_NOTAG = 2'd2;

	// Frame kinds; values below KIND_TRCK are delivered
	localparam logic [2:0] KIND_TIT2 = 3'd0;
	localparam logic [2:0] KIND_TALB = 3'd1;
	localparam logic [2:0] KIND_TPE1 = 3'd2;
	localparam logic [2:0] KIND_TYER = 3'd3;
	localparam logic [2:0] KIND_TRCK = 3'd4;
	localparam logic [2:0] KIND_NONE = 3'd7;

	// Frame IDs as big-endian words
	localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
	localparam logic [31:0] ID_TALB = 32'h5441_4C42;
	localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
	localparam logic [31:0] ID_TYER = 32'h5459_4552;
	localparam logic [31:0] ID_TRCK = 32'h5452_434B;

	// Header bytes and fields
	localparam logic [7:0] HDR_I     = 8'h49;
	localparam logic [7:0] HDR_D     = 8'h44;
	localparam logic [7:0] HDR_3     = 8'h33;
	localparam logic [7:0] VER_MAJ3  = 8'd3;
	localparam logic [7:0] VER_MAJ4  = 8'd4;
	localparam int         EXT_BIT   = 6;
	localparam logic [7:0] CAP_RESET = 8'd254;

	// One result word
	typedef struct packed {
		logic [1:0] event_res;
		logic [1:0] frame_kind;
		logic [7:0] text_coding;
		logic [7:0] text_byte;
		logic       last_text;
	} res_t;

	// Map a frame ID to its kind
	function automatic logic [2:0] kind_of(input logic [31:0] id);
		logic [2:0] k;
		case (id)
			ID_TIT2: k = KIND_TIT2;
			ID_TALB: k = KIND_TALB;
			ID_TPE1: k = KIND_TPE1;
			ID_TYER: k = KIND_TYER;
			ID_TRCK: k = KIND_TRCK;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/id3tfx_parser.sv @@
// ----------------------------------------------------------------------------
// id3tfx_parser
// Tag parser state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module id3tfx_parser
	import id3tfx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       file_start,
	input  logic [7:0] text_cap,
	output logic       res_valid,
	output res_t       res
);

	typedef enum logic [8:0] {
		PH_HDR     = 9'b000000001,
		PH_SIZE    = 9'b000000010,
		PH_EXTSIZE = 9'b000000100,
		PH_EXTSKIP = 9'b000001000,
		PH_ID      = 9'b000010000,
		PH_FHDR    = 9'b000100000,
		PH_BODY    = 9'b001000000,
		PH_ENDPEND = 9'b010000000,
		PH_DONE    = 9'b100000000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [2:0]  fc_q, fc_n;
	logic [7:0]  flags_q, flags_n;
	logic [27:0] tag_q, tag_n;
	logic [31:0] skip_q, skip_n;
	logic [31:0] id_q, id_n;
	logic [31:0] fleft_q, fleft_n;
	logic [2:0]  kind_q, kind_n;
	logic [7:0]  coding_q, coding_n;
	logic [7:0]  tcount_q, tcount_n;

	phase_t      ph;
	logic [2:0]  fc;
	logic [2:0]  fc_inc;
	logic        ok;
	logic        sent;

	// Next state and result for the byte in hand.
	// A file start only needs to reset phase and count: every other
	// field is loaded before the phase that reads it.
	always_comb begin
		ph        = file_start ? PH_HDR : phase_q;
		fc        = file_start ? 3'd0 : fc_q;
		fc_inc    = fc + 3'd1;
		phase_n   = ph;
		fc_n      = fc;
		flags_n   = flags_q;
		tag_n     = tag_q;
		skip_n    = skip_q;
		id_n      = id_q;
		fleft_n   = fleft_q;
		kind_n    = kind_q;
		coding_n  = coding_q;
		tcount_n  = tcount_q;
		ok        = 1'b1;
		sent      = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		case (ph)
			PH_HDR: begin
				case (fc)
					3'd0: ok = (data_byte == HDR_I);
					3'd1: ok = (data_byte == HDR_D);
					3'd2: ok = (data_byte == HDR_3);
					3'd3: ok = (data_byte == VER_MAJ3) || (data_byte == VER_MAJ4);
					3'd4: ok = (data_byte == 8'd0);
					default: flags_n = data_byte;
				endcase
				if (!ok) begin
					phase_n         = PH_DONE;
					res_valid       = 1'b1;
					res.event_res   = EV_NOTAG;
				end else if (fc >= 3'd5) begin
					phase_n = PH_SIZE;
					fc_n    = 3'd0;
					tag_n   = '0;
				end else begin
					fc_n = fc_inc;
				end
			end

			PH_SIZE: begin
				tag_n = {tag_q[20:0], data_byte[6:0]};
				fc_n  = fc_inc;
				if (fc_inc == 3'd4) begin
					fc_n = 3'd0;
					if (flags_q[EXT_BIT]) begin
						phase_n = PH_EXTSIZE;
						skip_n  = '0;
					end else if (tag_n == '0) begin
						phase_n       = PH_DONE;
						res_valid     = 1'b1;
						res.event_res = EV_END;
					end else begin
						phase_n = PH_ID;
						id_n    = '0;
					end
				end
			end

			PH_EXTSIZE: begin
				skip_n = {skip_q[23:0], data_byte};
				fc_n   = fc_inc;
				if (fc_inc == 3'd4) begin
					fc_n = 3'd0;
					if (skip_n >= {4'd0, tag_q}) begin
						phase_n       = PH_DONE;
						res_valid     = 1'b1;
						res.event_res = EV_END;
					end else begin
						tag_n = tag_q - skip_n[27:0];
						if (skip_n == '0) begin
							phase_n = PH_ID;
							id_n    = '0;
						end else begin
							phase_n = PH_EXTSKIP;
						end
					end
				end
			end

			// tag_left is known nonzero here: the skip was below it
			PH_EXTSKIP: begin
				skip_n = skip_q - 32'd1;
				if (skip_q == 32'd1) begin
					phase_n = PH_ID;
					fc_n    = 3'd0;
					id_n    = '0;
				end
			end

			PH_ID: begin
				id_n  = {id_q[23:0], data_byte};
				tag_n = (tag_q != '0) ? tag_q - 28'd1 : tag_q;
				fc_n  = fc_inc;
				if (tag_n == '0) begin
					phase_n       = PH_DONE;
					res_valid     = 1'b1;
					res.event_res = EV_END;
				end else if (fc_inc == 3'd4) begin
					if (id_n == '0 || tag_n < 28'd6) begin
						phase_n       = PH_DONE;
						res_valid     = 1'b1;
						res.event_res = EV_END;
					end else begin
						phase_n = PH_FHDR;
						fc_n    = 3'd0;
						fleft_n = '0;
					end
				end
			end

			// Size bytes, then clamp on byte 4, then commit on byte 5
			PH_FHDR: begin
				fc_n = fc_inc;
				if (fc < 3'd4) begin
					fleft_n = {fleft_q[23:0], data_byte};
				end
				if (fc == 3'd3) begin
					tag_n = tag_q - 28'd6;
				end
				if (fc == 3'd4 && fleft_q > {4'd0, tag_q}) begin
					fleft_n = {4'd0, tag_q};
				end
				if (fc == 3'd5) begin
					tag_n    = tag_q - fleft_q[27:0];
					kind_n   = kind_of(id_q);
					fc_n     = 3'd0;
					tcount_n = '0;
					if (fleft_q == '0) begin
						if (tag_q == '0) begin
							phase_n       = PH_DONE;
							res_valid     = 1'b1;
							res.event_res = EV_END;
						end else begin
							phase_n = PH_ID;
							id_n    = '0;
						end
					end else begin
						phase_n = PH_BODY;
					end
				end
			end

			PH_BODY: begin
				fleft_n = fleft_q - 32'd1;
				if (fc == 3'd0) begin
					coding_n = data_byte;
					fc_n     = 3'd1;
				end else if (kind_q < KIND_TRCK && tcount_q < text_cap) begin
					sent            = 1'b1;
					tcount_n        = tcount_q + 8'd1;
					res_valid       = 1'b1;
					res.event_res   = EV_TEXT;
					res.frame_kind  = kind_q[1:0];
					res.text_coding = coding_q;
					res.text_byte   = data_byte;
					res.last_text   = ({1'b0, tcount_q} + 9'd1 == {1'b0, text_cap}) ||
						(fleft_q == 32'd1);
				end
				if (fleft_q == 32'd1) begin
					if (tag_q == '0) begin
						if (sent) begin
							phase_n = PH_ENDPEND;
						end else begin
							phase_n       = PH_DONE;
							res_valid     = 1'b1;
							res.event_res = EV_END;
						end
					end else begin
						phase_n = PH_ID;
						fc_n    = 3'd0;
						id_n    = '0;
					end
				end
			end

			PH_ENDPEND: begin
				phase_n       = PH_DONE;
				res_valid     = 1'b1;
				res.event_res = EV_END;
			end

			default: begin
				phase_n = ph;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			fc_q    <= '0;
			kind_q  <= KIND_NONE;
		end else if (step) begin
			phase_q <= phase_n;
			fc_q    <= fc_n;
			kind_q  <= kind_n;
		end
	end

	// Counters and held fields
	always_ff @(posedge clk) begin
		if (step) begin
			flags_q  <= flags_n;
			tag_q    <= tag_n;
			skip_q   <= skip_n;
			id_q     <= id_n;
			fleft_q  <= fleft_n;
			coding_q <= coding_n;
			tcount_q <= tcount_n;
		end
	end

endmodule

@@ rtl/id3tfx_out_reg.sv @@
// ----------------------------------------------------------------------------
// id3tfx_out_reg
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
module id3tfx_out_reg
	import id3tfx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	output logic        free,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // text_coding, text_byte
	output logic [3:0]  m_axis_tuser,  // event_res, frame_kind
	output logic        m_axis_tlast   // last_text
);

	logic       valid_q;
	logic [15:0] data_q;
	logic [3:0]  user_q;
	logic        last_q;

	// Slot can take a word when empty or being drained
	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {res.text_byte, res.text_coding};
			user_q <= {res.frame_kind, res.event_res};
			last_q <= res.last_text;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = last_q;

endmodule

@@ rtl/id3v2_text_frame_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// id3v2_text_frame_extractor_unit
// Parses an ID3v2 tag from a byte stream and delivers text frame bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one file byte per word in tdata; tuser set marks the
//   first byte of a new file and restarts the parser.
//   m_axis carries at most one result word per input byte: a text byte of
//   a title, album, artist or year frame (tlast on the last one delivered
//   for that frame), a tag-end report, or a no-tag report.
//   cfg_valid/cfg_data writes the text cap (bytes per frame, reset 254);
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A byte is taken into an input register, then parsed into the result
//   register. One byte per cycle is sustained while m_axis is not stalled.
// Reset and stall:
//   Reset empties both registers and returns the parser to the header
//   check. While m_axis is stalled, bytes that give no result keep flowing;
//   a byte that gives a result waits in the input register.
// ----------------------------------------------------------------------------
module id3v2_text_frame_extractor_unit
	import id3tfx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // text_coding, text_byte
	output logic [3:0]  m_axis_tuser,  // event_res, frame_kind
	output logic        m_axis_tlast,  // last_text
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic [7:0] cap_q;
	logic       res_valid;
	res_t       res;
	logic       out_free;
	logic       advance;

	// Text cap register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Input register
	assign advance       = valid_s1 && (!res_valid || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Parser
	id3tfx_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.file_start (start_s1),
		.text_cap   (cap_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Result register
	id3tfx_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res_valid),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ rtl/id3tfx_checker.sv @@
// ----------------------------------------------------------------------------
// id3tfx_checker
// Port-level checks of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module id3tfx_checker
	import id3tfx_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled result word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// Only the three event codes appear
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[1:0] == EV_TEXT ||
		m_axis_tuser[1:0] == EV_END || m_axis_tuser[1:0] == EV_NOTAG))
		else $error("bad event code");

	// End and no-tag reports carry a zero payload
	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] != EV_TEXT |->
		m_axis_tdata == '0 && m_axis_tuser[3:2] == 2'd0 && !m_axis_tlast)
		else $error("report word with payload");

	// A fresh result follows an accepted input byte
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without an input byte");

endmodule

bind id3v2_text_frame_extractor_unit id3tfx_checker u_checker (.*);
